/* rtl/core/mcva_pkg.sv */
`timescale 1ns / 1ps

package mcva_pkg;

  localparam int CHANNELS    = 16;
  localparam int VOICE_LIMIT = 16;

  localparam logic [12:0] PRESSURE_MAX = 13'd4096;

  // Event kinds.
  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_BEND     = 2'd2;
  localparam logic [1:0] KIND_PRESSURE = 2'd3;

  // Configuration register indexes.
  localparam logic REG_MAX_VOICES   = 1'b0;
  localparam logic REG_MEMBER_COUNT = 1'b1;

  localparam logic [4:0] MASTER_CHANNEL = 5'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_ALLOC,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic scan_init;
    logic scan_step;
    logic alloc;
    logic result_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_needed;
    logic scan_hit;
    logic scan_last;
  } dp_status_t;

endpackage

/* rtl/core/mcva_ctrl.sv */
`timescale 1ns / 1ps

module mcva_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mcva_pkg::dp_status_t status,
  output mcva_pkg::ctrl_cmd_t  cmd
);

  mcva_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == mcva_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mcva_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mcva_pkg::ST_DECODE;
      end
      mcva_pkg::ST_DECODE: begin
        state_nxt = status.scan_needed ? mcva_pkg::ST_SCAN : mcva_pkg::ST_RESULT;
      end
      mcva_pkg::ST_SCAN: begin
        if (status.scan_hit || status.scan_last) state_nxt = mcva_pkg::ST_ALLOC;
      end
      mcva_pkg::ST_ALLOC: begin
        state_nxt = mcva_pkg::ST_RESULT;
      end
      mcva_pkg::ST_RESULT: begin
        if (out_free) state_nxt = mcva_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mcva_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      mcva_pkg::ST_IDLE: begin
        cmd.capture = in_valid;
      end
      mcva_pkg::ST_DECODE: begin
        cmd.scan_init = status.scan_needed;
        cmd.update    = !status.scan_needed;
      end
      mcva_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      mcva_pkg::ST_ALLOC: begin
        cmd.alloc = 1'b1;
      end
      mcva_pkg::ST_RESULT: begin
        cmd.result_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.result_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcva_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/mcva_dp.sv */
`timescale 1ns / 1ps

module mcva_dp #(
  parameter int VOICES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [4:0]           cfg_data,
  input  logic [1:0]           in_kind,
  input  logic [4:0]           in_channel,
  input  logic signed [15:0]   in_value,
  input  logic [3:0]           in_query_voice,
  input  mcva_pkg::ctrl_cmd_t  cmd,
  output mcva_pkg::dp_status_t status,
  output logic                 out_channel_assigned,
  output logic [3:0]           out_channel_voice,
  output logic signed [15:0]   out_pitch_offset,
  output logic [12:0]          out_pressure_out
);

  localparam int NV = (VOICES > mcva_pkg::VOICE_LIMIT) ? mcva_pkg::VOICE_LIMIT : VOICES;
  localparam int VW = (NV > 1) ? $clog2(NV) : 1;
  localparam int CH = mcva_pkg::CHANNELS;
  localparam logic [4:0] NV_CAP = 5'(NV);

  // Configuration.
  logic [4:0] max_voices_r;
  logic [3:0] member_count_r;

  // Captured event.
  logic [1:0]         kind_r;
  logic [4:0]         chan_r;
  logic signed [15:0] value_r;
  logic [3:0]         query_r;

  // Allocator state.
  logic [CH-1:0]      map_valid_r;
  logic [VW-1:0]      map_voice_r [CH];
  logic signed [15:0] vbend_r [NV];
  logic [12:0]        vpres_r [NV];
  logic [NV-1:0]      vact_r;
  logic signed [15:0] mbend_r;
  logic [12:0]        mpres_r;
  logic [VW-1:0]      cursor_r;

  // Scan.
  logic [VW-1:0] scan_c_r;
  logic [VW-1:0] scan_n_r;
  logic [VW-1:0] chosen_r;

  logic          in_range;
  logic [3:0]    idx;
  logic          is_member;
  logic          cur_valid;
  logic [VW-1:0] cur_voice;
  logic [VW-1:0] last_voice;
  logic [12:0]   pres_clamped;
  logic          clear_all;
  logic          q_ok;
  logic [VW-1:0] qi;
  logic signed [16:0] pitch_sum;
  logic signed [15:0] pitch_sat;
  logic [12:0]   pres_sel;

  assign in_range   = (chan_r != 5'd0) && (chan_r <= 5'(CH));
  assign idx        = 4'(chan_r - 5'd1);
  assign is_member  = (member_count_r != 4'd0) && (chan_r >= 5'd2) &&
                      (chan_r <= ({1'b0, member_count_r} + 5'd1));
  assign cur_valid  = in_range && map_valid_r[idx];
  assign cur_voice  = map_voice_r[idx];
  assign last_voice = VW'(max_voices_r - 5'd1);

  assign pres_clamped = value_r[15] ? 13'd0 :
                        (value_r > 16'sd4096) ? mcva_pkg::PRESSURE_MAX : value_r[12:0];

  assign clear_all = cfg_we && (cfg_index == mcva_pkg::REG_MAX_VOICES);

  assign status.scan_needed = in_range && (kind_r == mcva_pkg::KIND_NOTE_ON) && is_member &&
                              (max_voices_r != 5'd0) && !cur_valid;
  assign status.scan_hit    = !vact_r[scan_c_r];
  assign status.scan_last   = (scan_n_r == last_voice);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_voices_r   <= NV_CAP;
      member_count_r <= 4'd15;
    end else if (cfg_we) begin
      if (cfg_index == mcva_pkg::REG_MAX_VOICES) begin
        max_voices_r <= (cfg_data > NV_CAP) ? NV_CAP : cfg_data;
      end else begin
        member_count_r <= cfg_data[3:0];
      end
    end
  end

  // Event capture.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= in_kind;
      chan_r  <= in_channel;
      value_r <= in_value;
      query_r <= in_query_voice;
    end
  end

  // Round-robin scan for a free voice.
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_c_r <= cursor_r;
      scan_n_r <= '0;
      chosen_r <= cursor_r;
    end else if (cmd.scan_step) begin
      if (!vact_r[scan_c_r]) chosen_r <= scan_c_r;
      scan_c_r <= (scan_c_r == last_voice) ? '0 : scan_c_r + VW'(1);
      scan_n_r <= scan_n_r + VW'(1);
    end
  end

  // Allocator state update.
  always_ff @(posedge clk) begin
    if (!rst_n || clear_all) begin
      map_valid_r <= '0;
      vact_r      <= '0;
      mbend_r     <= '0;
      mpres_r     <= '0;
      cursor_r    <= '0;
      for (int i = 0; i < CH; i++) map_voice_r[i] <= '0;
      for (int i = 0; i < NV; i++) begin
        vbend_r[i] <= '0;
        vpres_r[i] <= '0;
      end
    end else if (cmd.alloc) begin
      for (int i = 0; i < CH; i++) begin
        if (map_valid_r[i] && (map_voice_r[i] == chosen_r)) map_valid_r[i] <= 1'b0;
      end
      map_valid_r[idx]  <= 1'b1;
      map_voice_r[idx]  <= chosen_r;
      cursor_r          <= (chosen_r == last_voice) ? '0 : chosen_r + VW'(1);
      vbend_r[chosen_r] <= '0;
      vpres_r[chosen_r] <= '0;
      vact_r[chosen_r]  <= 1'b1;
    end else if (cmd.update && in_range) begin
      case (kind_r)
        mcva_pkg::KIND_NOTE_ON: begin
          // Retrigger on a channel that already holds a voice.
          if (is_member && (max_voices_r != 5'd0) && cur_valid) begin
            vbend_r[cur_voice] <= '0;
            vpres_r[cur_voice] <= '0;
            vact_r[cur_voice]  <= 1'b1;
          end
        end
        mcva_pkg::KIND_NOTE_OFF: begin
          if (cur_valid) begin
            vact_r[cur_voice] <= 1'b0;
            map_valid_r[idx]  <= 1'b0;
          end
        end
        mcva_pkg::KIND_BEND: begin
          if (chan_r == mcva_pkg::MASTER_CHANNEL) begin
            mbend_r <= value_r;
          end else if (is_member && cur_valid) begin
            vbend_r[cur_voice] <= value_r;
          end
        end
        mcva_pkg::KIND_PRESSURE: begin
          if (chan_r == mcva_pkg::MASTER_CHANNEL) begin
            mpres_r <= pres_clamped;
          end else if (is_member && cur_valid) begin
            vpres_r[cur_voice] <= pres_clamped;
          end
        end
        default: begin
          mbend_r <= mbend_r;
        end
      endcase
    end
  end

  // Result computation on the updated state.
  assign q_ok      = ({1'b0, query_r} < max_voices_r);
  assign qi        = query_r[VW-1:0];
  assign pitch_sum = 17'(vbend_r[qi]) + 17'(mbend_r);
  assign pitch_sat = (pitch_sum[16] != pitch_sum[15]) ?
                     (pitch_sum[16] ? 16'sh8000 : 16'sh7fff) : pitch_sum[15:0];
  assign pres_sel  = (vpres_r[qi] != 13'd0) ? vpres_r[qi] : mpres_r;

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_channel_assigned <= cur_valid;
      out_channel_voice    <= cur_valid ? 4'(cur_voice) : 4'd0;
      out_pitch_offset     <= q_ok ? pitch_sat : 16'sd0;
      out_pressure_out     <= q_ok ? pres_sel : 13'd0;
    end
  end

endmodule

/* rtl/core/mpe_channel_voice_allocator.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Word contents
// in_       input      in_valid / in_ready    kind, channel, value, query_voice
// out_      output     out_valid / out_ready  channel_assigned, channel_voice,
//                                             pitch_offset, pressure_out
// cfg_      input      cfg_we (no wait)       index 0 max_voices, index 1 member_count
//
// A word that allocates no voice passes the idle, decode and result states, and
// its result is loaded into the output register in the result state. A note on
// that allocates also passes the scan state, which tests voices from the cursor
// (at most max_voices of them), and the allocation state.
// One word is processed at a time; the next word is accepted once the result
// has moved into the output register, even while that result is still stalled.
// Reset (synchronous, active low) clears all allocator state, as does a write
// of max_voices; no clearing pass is needed.

module mpe_channel_voice_allocator #(
  parameter int VOICES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic [4:0]         in_channel,
  input  logic signed [15:0] in_value,
  input  logic [3:0]         in_query_voice,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_channel_assigned,
  output logic [3:0]         out_channel_voice,
  output logic signed [15:0] out_pitch_offset,
  output logic [12:0]        out_pressure_out,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data
);

  // The controller sequences decode, scan, allocation and result load; the
  // datapath holds the channel map, per-voice expression values and the
  // master channel values, and reports what the controller needs to branch.
  mcva_pkg::ctrl_cmd_t  cmd;
  mcva_pkg::dp_status_t status;

  mcva_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The pool is stored for at most sixteen voices, since max_voices saturates
  // there regardless of how large VOICES is set.
  mcva_dp #(
    .VOICES (VOICES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_kind              (in_kind),
    .in_channel           (in_channel),
    .in_value             (in_value),
    .in_query_voice       (in_query_voice),
    .cmd                  (cmd),
    .status               (status),
    .out_channel_assigned (out_channel_assigned),
    .out_channel_voice    (out_channel_voice),
    .out_pitch_offset     (out_pitch_offset),
    .out_pressure_out     (out_pressure_out)
  );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

// Self-checking bench for the MPE lower-zone voice allocator.
//
// Every word that the block accepts is also run through a behavioral copy of
// the allocator kept in this file: channel map, per-voice bend and pressure,
// voice activity, master values and the round-robin cursor. That copy yields
// the report the block must return for the word, and the report is queued.
// A checker compares every accepted report against the oldest queued one.
//
// The run goes through directed events first (field extremes, saturation,
// clamping, ignored channels, voice stealing, member count changes and the
// register extremes), then long phases of random traffic under several pool
// and zone sizes. The sender works in bursts and the receiver stalls on a
// pattern of its own, so gaps land on every stage of the block's work.

module testbench;

  localparam int NUM_CHANNELS   = 16;
  localparam int POOL_LIMIT     = 16;
  // The longest word is a note on that scans the whole pool; this settling
  // time covers any word still in flight.
  localparam int SETTLE_CYCLES  = 24;
  // Cycles without any accepted word, in or out, before the run is abandoned.
  // The worst legal gap is one full scan plus the longest sender gap plus a
  // long receiver stall, far below this.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_WORDS    = 190;

  // One report word as the block returns it.
  typedef struct packed {
    logic               assigned;
    logic [3:0]         voice;
    logic signed [15:0] pitch;
    logic [12:0]        pressure;
  } voice_report_t;

  // Clock, reset and block inputs, all known from time zero.
  logic               clk;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic [1:0]         in_kind        = mcva_pkg::KIND_NOTE_OFF;
  logic [4:0]         in_channel     = '0;
  logic signed [15:0] in_value       = '0;
  logic [3:0]         in_query_voice = '0;
  logic               out_ready      = 1'b0;
  logic               cfg_we         = 1'b0;
  logic               cfg_index      = mcva_pkg::REG_MAX_VOICES;
  logic [4:0]         cfg_data       = '0;

  logic               in_ready;
  logic               out_valid;
  logic               out_channel_assigned;
  logic [3:0]         out_channel_voice;
  logic signed [15:0] out_pitch_offset;
  logic [12:0]        out_pressure_out;

  // Behavioral copy of the allocator.
  int                 pool_size;
  int                 members;
  int                 cursor;
  logic               map_ok [NUM_CHANNELS];
  logic [3:0]         map_v  [NUM_CHANNELS];
  logic signed [15:0] v_bend [POOL_LIMIT];
  logic [12:0]        v_pres [POOL_LIMIT];
  logic               v_on   [POOL_LIMIT];
  logic signed [15:0] m_bend;
  logic [12:0]        m_pres;

  // Reports that the block still owes, oldest first.
  voice_report_t pending_reports[$];
  voice_report_t want_r;
  voice_report_t got_r;

  int error_count = 0;
  int quiet_cycles = 0;
  int burst_left = 0;

  // Receiver stall pattern state.
  int ready_mode = 0;
  int mode_left = 0;
  int pattern_step = 0;

  mpe_channel_voice_allocator DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_kind              (in_kind),
    .in_channel           (in_channel),
    .in_value             (in_value),
    .in_query_voice       (in_query_voice),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_channel_assigned (out_channel_assigned),
    .out_channel_voice    (out_channel_voice),
    .out_pitch_offset     (out_pitch_offset),
    .out_pressure_out     (out_pressure_out),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Allocator behavior
  // ---------------------------------------------------------------------------

  // Reset and every max_voices write empty the whole allocator, but the zone
  // size survives a max_voices write.
  function automatic void clear_allocator();
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      map_ok[i] = 1'b0;
      map_v[i]  = '0;
    end
    for (int i = 0; i < POOL_LIMIT; i++) begin
      v_bend[i] = '0;
      v_pres[i] = '0;
      v_on[i]   = 1'b0;
    end
    m_bend = '0;
    m_pres = '0;
    cursor = 0;
  endfunction

  function automatic logic member_channel(input logic [4:0] ch);
    return members > 0 && ch >= 2 && ch <= 1 + members;
  endfunction

  // Applies one event word to the allocator copy and returns the report that
  // the block must produce for it. The report is formed after the update.
  function automatic voice_report_t allocate_and_report(input logic [1:0] kind,
                                                        input logic [4:0] ch,
                                                        input logic signed [15:0] value,
                                                        input logic [3:0] q);
    voice_report_t      rep;
    logic               in_range;
    logic               found;
    int                 slot;
    int                 v;
    int                 c;
    logic [12:0]        clamped;
    logic signed [16:0] sum;

    in_range = ch >= 1 && ch <= NUM_CHANNELS;
    slot = in_range ? ch - 1 : 0;
    rep = '0;

    if (in_range) begin
      case (kind)
        mcva_pkg::KIND_NOTE_ON: begin
          if (member_channel(ch) && pool_size != 0) begin
            if (map_ok[slot]) begin
              // A retriggered channel keeps its voice.
              v = int'(map_v[slot]);
            end else begin
              // Scan from the cursor for a free voice; with none free the
              // voice at the cursor is stolen.
              v = cursor;
              found = 1'b0;
              for (int i = 0; i < pool_size; i++) begin
                c = (cursor + i) % pool_size;
                if (!found && !v_on[c]) begin
                  v = c;
                  found = 1'b1;
                end
              end
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (map_ok[i] && map_v[i] == v) map_ok[i] = 1'b0;
              end
              map_ok[slot] = 1'b1;
              map_v[slot] = 4'(v);
              cursor = (v + 1) % pool_size;
            end
            v_bend[v] = '0;
            v_pres[v] = '0;
            v_on[v] = 1'b1;
          end
        end
        mcva_pkg::KIND_NOTE_OFF: begin
          // Also frees channels that dropped out of the zone.
          if (map_ok[slot]) begin
            v_on[map_v[slot]] = 1'b0;
            map_ok[slot] = 1'b0;
          end
        end
        default: begin
          if (value < 0) clamped = '0;
          else if (value > $signed({3'b000, mcva_pkg::PRESSURE_MAX}))
            clamped = mcva_pkg::PRESSURE_MAX;
          else clamped = value[12:0];
          if (ch == mcva_pkg::MASTER_CHANNEL) begin
            if (kind == mcva_pkg::KIND_BEND) m_bend = value;
            else m_pres = clamped;
          end else if (member_channel(ch) && map_ok[slot]) begin
            if (kind == mcva_pkg::KIND_BEND) v_bend[map_v[slot]] = value;
            else v_pres[map_v[slot]] = clamped;
          end
        end
      endcase
    end

    if (q < pool_size) begin
      sum = v_bend[q] + m_bend;
      if (sum > 17'sd32767) rep.pitch = 16'sh7FFF;
      else if (sum < -17'sd32768) rep.pitch = 16'sh8000;
      else rep.pitch = sum[15:0];
      rep.pressure = v_pres[q] != 0 ? v_pres[q] : m_pres;
    end

    if (in_range && map_ok[slot]) begin
      rep.assigned = 1'b1;
      rep.voice = map_v[slot];
    end
    return rep;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Presents one word and holds it until the block takes it. Valid is left
  // high so that a following word goes out back to back.
  task automatic send_event(input logic [1:0] kind, input logic [4:0] ch,
                            input logic signed [15:0] value, input logic [3:0] q);
    @(negedge clk);
    in_valid = 1'b1;
    in_kind = kind;
    in_channel = ch;
    in_value = value;
    in_query_voice = q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_reports.push_back(allocate_and_report(kind, ch, value, q));
  endtask

  // Drops valid for a number of cycles. The payload is scrambled meanwhile,
  // since the block must not look at it without valid.
  task automatic idle_sender(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    in_kind = 2'($urandom);
    in_channel = 5'($urandom);
    in_value = 16'($urandom);
    in_query_voice = 4'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Bursts of random length separated by random gaps, and now and then a
  // burst that runs straight into the next one.
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
    end
    burst_left--;
  endtask

  // Stops sending until every owed report has come back.
  task automatic pause_until_drained();
    idle_sender(1);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Registers are only written with the block idle.
  task automatic write_reg(input logic idx, input logic [4:0] data);
    pause_until_drained();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == mcva_pkg::REG_MAX_VOICES) begin
      pool_size = data > POOL_LIMIT ? POOL_LIMIT : int'(data);
      clear_allocator();
    end else begin
      members = int'(data[3:0]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side and checking
  // ---------------------------------------------------------------------------

  // The receiver switches between modes every so often: always ready, a coin
  // toss, mostly stalled, and a fixed three-in-seven pattern.
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(16, 200);
    end else begin
      mode_left--;
    end
    pattern_step = (pattern_step + 1) % 7;
    case (ready_mode)
      0: out_ready = 1'b1;
      1: out_ready = 1'($urandom_range(0, 1));
      2: out_ready = $urandom_range(0, 3) == 0;
      default: out_ready = pattern_step < 3;
    endcase
  end

  task automatic log_mismatch(input string what);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s: expected assigned=%0b voice=%0d pitch=%0d pressure=%0d",
               $realtime, what, want_r.assigned, want_r.voice, want_r.pitch,
               want_r.pressure);
      $display("%0t: %s: actual   assigned=%0b voice=%0d pitch=%0d pressure=%0d",
               $realtime, what, got_r.assigned, got_r.voice, got_r.pitch,
               got_r.pressure);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_r = '{out_channel_assigned, out_channel_voice, out_pitch_offset,
                out_pressure_out};
      if (pending_reports.size() == 0) begin
        want_r = '0;
        log_mismatch("report with none owed");
      end else begin
        want_r = pending_reports.pop_front();
        if (got_r !== want_r) log_mismatch("report mismatch");
      end
    end
  end

  // Watchdog: any accepted word on either side counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Single events on the reset configuration: field extremes, bend
  // saturation, pressure clamping and the fallback to master pressure,
  // retrigger, ignored channels and note off on idle channels.
  task automatic test_single_events();
    send_event(mcva_pkg::KIND_BEND, mcva_pkg::MASTER_CHANNEL, 16'sh7FFF, 4'd0);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd2, 16'sh5555, 4'd0);
    send_event(mcva_pkg::KIND_BEND, 5'd2, 16'sh7FFF, 4'd0);      // positive saturation
    send_event(mcva_pkg::KIND_BEND, mcva_pkg::MASTER_CHANNEL, 16'sh8000, 4'd0);
    send_event(mcva_pkg::KIND_BEND, 5'd2, 16'sh8000, 4'd0);      // negative saturation
    send_event(mcva_pkg::KIND_PRESSURE, mcva_pkg::MASTER_CHANNEL, 16'sd5000, 4'd0);
    send_event(mcva_pkg::KIND_PRESSURE, 5'd2, -16'sd5, 4'd0);    // clamps to zero
    send_event(mcva_pkg::KIND_PRESSURE, 5'd2, 16'sd4096, 4'd0);
    send_event(mcva_pkg::KIND_PRESSURE, 5'd2, 16'sd1, 4'd0);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd16, 16'shAAAA, 4'd1);
    send_event(mcva_pkg::KIND_BEND, 5'd16, 16'sh0180, 4'd1);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd2, '0, 4'd0);          // retrigger keeps voice
    send_event(mcva_pkg::KIND_NOTE_ON, mcva_pkg::MASTER_CHANNEL, '0, 4'd2);
    send_event(mcva_pkg::KIND_BEND, 5'd0, 16'sh1234, 4'd15);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd17, '0, 4'd15);
    send_event(mcva_pkg::KIND_PRESSURE, 5'd31, 16'sd100, 4'd15);
    send_event(mcva_pkg::KIND_NOTE_OFF, 5'd2, '0, 4'd0);
    send_event(mcva_pkg::KIND_NOTE_OFF, 5'd2, '0, 4'd0);         // already free
    send_event(mcva_pkg::KIND_BEND, 5'd2, 16'sd100, 4'd0);       // no voice held
    send_event(mcva_pkg::KIND_PRESSURE, mcva_pkg::MASTER_CHANNEL, -16'sd1, 4'd1);
    send_event(mcva_pkg::KIND_NOTE_OFF, mcva_pkg::MASTER_CHANNEL, '0, 4'd1);
    send_event(mcva_pkg::KIND_NOTE_OFF, 5'd16, 16'sh7FFF, 4'd15);
  endtask

  // A small pool runs out and steals at the cursor; a shrunken zone keeps
  // the voices it already handed out until note off.
  task automatic test_voice_stealing();
    write_reg(mcva_pkg::REG_MAX_VOICES, 5'd3);
    for (int ch = 2; ch <= 6; ch++) begin
      send_event(mcva_pkg::KIND_NOTE_ON, 5'(ch), '0, 4'(ch % 3));
    end
    send_event(mcva_pkg::KIND_BEND, 5'd2, 16'sd256, 4'd0);       // channel was stolen from
    send_event(mcva_pkg::KIND_NOTE_OFF, 5'd4, '0, 4'd2);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd7, '0, 4'd2);
    write_reg(mcva_pkg::REG_MEMBER_COUNT, 5'd2);
    send_event(mcva_pkg::KIND_BEND, 5'd6, 16'sd300, 4'd1);       // outside the zone now
    send_event(mcva_pkg::KIND_PRESSURE, 5'd5, 16'sd900, 4'd0);
    send_event(mcva_pkg::KIND_NOTE_OFF, 5'd6, '0, 4'd1);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd5, '0, 4'd0);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd3, '0, 4'd1);
    write_reg(mcva_pkg::REG_MEMBER_COUNT, 5'd15);
  endtask

  // Register extremes: an empty pool, oversized pool values that saturate,
  // an empty zone, a member count write with its upper bit set, a one-voice
  // pool and a query beyond the pool.
  task automatic test_register_extremes();
    write_reg(mcva_pkg::REG_MAX_VOICES, 5'd0);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd2, '0, 4'd0);
    send_event(mcva_pkg::KIND_BEND, mcva_pkg::MASTER_CHANNEL, 16'sd512, 4'd0);
    write_reg(mcva_pkg::REG_MAX_VOICES, 5'd31);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd9, '0, 4'd15);
    write_reg(mcva_pkg::REG_MEMBER_COUNT, 5'd0);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd3, '0, 4'd0);
    send_event(mcva_pkg::KIND_PRESSURE, mcva_pkg::MASTER_CHANNEL, 16'sd2048, 4'd3);
    write_reg(mcva_pkg::REG_MEMBER_COUNT, 5'd16);                // upper bit dropped
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd2, '0, 4'd0);
    write_reg(mcva_pkg::REG_MAX_VOICES, 5'd1);
    write_reg(mcva_pkg::REG_MEMBER_COUNT, 5'd15);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd2, '0, 4'd0);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd16, '0, 4'd1);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd2, '0, 4'd0);
    write_reg(mcva_pkg::REG_MAX_VOICES, 5'd20);
    send_event(mcva_pkg::KIND_NOTE_ON, 5'd4, '0, 4'd15);
  endtask

  // Random traffic in phases, each with its own pool and zone size. Most
  // words land on member channels so that allocation, stealing and per-voice
  // expression are exercised; the rest hit the master channel, channels
  // outside the zone and channels outside the valid range.
  task automatic test_random_traffic();
    int                 pick;
    logic [1:0]         kind;
    logic [4:0]         ch;
    logic signed [15:0] value;
    logic [3:0]         q;
    logic [4:0]         pool_pick [9];
    logic [4:0]         zone_pick [6];

    pool_pick = '{5'd16, 5'd31, 5'd1, 5'd2, 5'd5, 5'd8, 5'd12, 5'd0, 5'd20};
    zone_pick = '{5'd15, 5'd0, 5'd1, 5'd3, 5'd7, 5'd10};

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        write_reg(mcva_pkg::REG_MAX_VOICES, 5'd16);
        write_reg(mcva_pkg::REG_MEMBER_COUNT, 5'd15);
      end else begin
        // The picks include an empty pool and an empty zone.
        write_reg(mcva_pkg::REG_MAX_VOICES, pool_pick[$urandom_range(0, 8)]);
        write_reg(mcva_pkg::REG_MEMBER_COUNT, zone_pick[$urandom_range(0, 5)]);
      end

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n == PHASE_WORDS / 2) begin
          write_reg(mcva_pkg::REG_MEMBER_COUNT, 5'($urandom_range(0, 15)));
        end
        if ($urandom_range(0, 99) == 0) pause_until_drained();

        pick = $urandom_range(0, 99);
        if (pick < 75 && members > 0) ch = 5'($urandom_range(2, 1 + members));
        else if (pick < 85) ch = mcva_pkg::MASTER_CHANNEL;
        else if (pick < 92) ch = 5'($urandom_range(1, NUM_CHANNELS));
        else ch = 5'($urandom_range(0, 31));

        pick = $urandom_range(0, 99);
        if (pick < 35) kind = mcva_pkg::KIND_NOTE_ON;
        else if (pick < 60) kind = mcva_pkg::KIND_NOTE_OFF;
        else if (pick < 80) kind = mcva_pkg::KIND_BEND;
        else kind = mcva_pkg::KIND_PRESSURE;

        pick = $urandom_range(0, 9);
        if (kind == mcva_pkg::KIND_BEND) begin
          if (pick == 0) value = 16'sh7FFF;
          else if (pick == 1) value = 16'sh8000;
          else if (pick < 6) value = 16'($urandom_range(0, 2047) - 1024);
          else value = 16'($urandom);
        end else if (kind == mcva_pkg::KIND_PRESSURE) begin
          if (pick == 0) value = '0;
          else if (pick == 1) value = 16'(mcva_pkg::PRESSURE_MAX);
          else if (pick == 2) value = 16'($urandom);
          else value = 16'($urandom_range(0, 4096));
        end else begin
          value = 16'($urandom);
        end

        if (pool_size > 0 && $urandom_range(0, 3) != 0) begin
          q = 4'($urandom_range(0, pool_size - 1));
        end else begin
          q = 4'($urandom_range(0, 15));
        end

        pace_sender();
        send_event(kind, ch, value, q);
      end
    end
  endtask

  initial begin
    pool_size = POOL_LIMIT;
    members = 15;
    clear_allocator();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_events();
    test_voice_stealing();
    test_register_extremes();
    test_random_traffic();

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
